// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Same, on the block clock clk_i and reset rst_ni.
`define ASSERT_CLK(label, prop) `ASSERT_RST(label, clk_i, rst_ni, prop)

`endif

// ===== rtl/core/lires_pkg.sv =====
`timescale 1ns / 1ps

package lires_pkg;

  localparam int LANES       = 8;
  localparam int SAMPLE_BITS = 24;
  localparam int RATE_BITS   = 20;
  localparam int PHASE_BITS  = 19;
  localparam int CH_BITS     = 4;
  localparam int SKIP_BITS   = 3;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [RATE_BITS-1:0] MAX_RATE       = RATE_BITS'(1 << 19);
  localparam logic [RATE_BITS-1:0] RST_INPUT_RATE  = RATE_BITS'(48000);
  localparam logic [RATE_BITS-1:0] RST_OUTPUT_RATE = RATE_BITS'(48000);
  localparam logic [CH_BITS-1:0]   RST_ACTIVE_CH   = CH_BITS'(2);

  // register indexes of the configuration port
  localparam logic [CFG_IDX_BITS-1:0] CFG_INPUT_RATE  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_OUTPUT_RATE = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] CFG_ACTIVE_CH   = CFG_IDX_BITS'(2);

  typedef logic [SAMPLE_BITS-1:0] smp_t;
  typedef smp_t [LANES-1:0] smp_arr_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_7;
    logic signed [SAMPLE_BITS-1:0] sample_6;
    logic signed [SAMPLE_BITS-1:0] sample_5;
    logic signed [SAMPLE_BITS-1:0] sample_4;
    logic signed [SAMPLE_BITS-1:0] sample_3;
    logic signed [SAMPLE_BITS-1:0] sample_2;
    logic signed [SAMPLE_BITS-1:0] sample_1;
    logic signed [SAMPLE_BITS-1:0] sample_0;
  } in_frame_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_7;
    logic signed [SAMPLE_BITS-1:0] out_6;
    logic signed [SAMPLE_BITS-1:0] out_5;
    logic signed [SAMPLE_BITS-1:0] out_4;
    logic signed [SAMPLE_BITS-1:0] out_3;
    logic signed [SAMPLE_BITS-1:0] out_2;
    logic signed [SAMPLE_BITS-1:0] out_1;
    logic signed [SAMPLE_BITS-1:0] out_0;
    logic                          last_of_run;
  } out_frame_t;

  // controller to merge stage
  typedef struct packed {
    logic load;
    logic last;
  } mrg_ctrl_t;

  function automatic smp_arr_t in_to_arr(in_frame_t f);
    smp_arr_t a;
    a[0] = f.sample_0;
    a[1] = f.sample_1;
    a[2] = f.sample_2;
    a[3] = f.sample_3;
    a[4] = f.sample_4;
    a[5] = f.sample_5;
    a[6] = f.sample_6;
    a[7] = f.sample_7;
    return a;
  endfunction

  function automatic out_frame_t arr_to_out(smp_arr_t a, logic last);
    out_frame_t f;
    f.out_0       = a[0];
    f.out_1       = a[1];
    f.out_2       = a[2];
    f.out_3       = a[3];
    f.out_4       = a[4];
    f.out_5       = a[5];
    f.out_6       = a[6];
    f.out_7       = a[7];
    f.last_of_run = last;
    return f;
  endfunction

endpackage

// ===== rtl/core/lires_div.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Restoring divider, one quotient bit per cycle:
// quot = floor(dividend * 2^FRAC_BITS / divisor), dividend < divisor.
module lires_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [lires_pkg::RATE_BITS-1:0]  dividend_i,
  input  logic [lires_pkg::RATE_BITS-1:0]  divisor_i,
  output logic [FRAC_BITS-1:0]             quot_o,
  output logic                             done_o
);

  localparam int RB = lires_pkg::RATE_BITS;
  localparam int CW = $clog2(FRAC_BITS + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [RB-1:0] rem_q;
  logic [FRAC_BITS-1:0] quot_q;
  logic [RB:0]   trial;
  logic          fits;

  assign trial = {rem_q, 1'b0};
  assign fits  = trial >= {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(FRAC_BITS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i;
      quot_q <= '0;
    end else if (busy_q) begin
      // remainder stays below the divisor, so the top bit drops out
      rem_q  <= fits ? RB'(trial - {1'b0, divisor_i}) : trial[RB-1:0];
      quot_q <= {quot_q[FRAC_BITS-2:0], fits};
    end
  end

  assign quot_o = quot_q;
  assign done_o = done_q;

  `ASSERT_CLK(a_div_no_restart, start_i |-> !busy_q)

endmodule

// ===== rtl/core/lires_lane.sv =====
`timescale 1ns / 1ps

// One channel: y = prev + floor((cur - prev) * frac / 2^FRAC_BITS), wrapped
// to the sample width. Two register stages, multiply then add.
module lires_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  lires_pkg::smp_t         cur_i,
  input  lires_pkg::smp_t         prev_i,
  input  logic [FRAC_BITS-1:0]    frac_i,
  output logic                    done_o,
  output lires_pkg::smp_t         y_o
);

  localparam int SB = lires_pkg::SAMPLE_BITS;
  localparam int PW = SB + FRAC_BITS + 2;

  logic signed [SB:0]   diff;
  logic signed [PW-1:0] prod_q;
  logic signed [PW-1:0] shifted;
  lires_pkg::smp_t      y_d, y_q;
  logic                 v1_q, v2_q;

  assign diff = $signed({cur_i[SB-1], cur_i}) - $signed({prev_i[SB-1], prev_i});

  always_ff @(posedge clk_i) begin
    prod_q <= PW'(diff) * PW'($signed({1'b0, frac_i}));
  end

  // arithmetic shift floors toward minus infinity
  assign shifted = prod_q >>> FRAC_BITS;
  assign y_d     = prev_i + shifted[SB-1:0];

  always_ff @(posedge clk_i) begin
    y_q <= y_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
    end
  end

  assign done_o = v2_q;
  assign y_o    = y_q;

endmodule

// ===== rtl/core/lires_merge.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Gathers the lane results into one output frame, zeroes lanes past the
// active channel count, and holds the frame until the receiver takes it.
module lires_merge (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  lires_pkg::mrg_ctrl_t               ctrl_i,
  input  lires_pkg::smp_arr_t                lane_y_i,
  input  logic [lires_pkg::CH_BITS-1:0]      ch_i,
  output logic                               ready_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output lires_pkg::out_frame_t              out_data_o
);

  localparam int LN = lires_pkg::LANES;

  lires_pkg::smp_arr_t   masked;
  lires_pkg::out_frame_t data_q;
  logic                  valid_q;

  for (genvar i = 0; i < LN; i++) begin : g_mask
    assign masked[i] = (lires_pkg::CH_BITS'(i) < ch_i) ? lane_y_i[i] : '0;
  end

  assign ready_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.load) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      data_q <= lires_pkg::arr_to_out(masked, ctrl_i.last);
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  `ASSERT_CLK(a_load_when_free, ctrl_i.load |-> !valid_q || !out_stall_i)

endmodule

// ===== rtl/core/linear_interp_audio_resampler_top.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Linear-interpolation audio resampler, one multichannel frame per transaction.
// Input channel: in_valid_i / in_stall_o / in_data_i, one frame of eight
// signed Q1.23 samples. Output channel: out_valid_o / out_stall_i /
// out_data_o, zero to MAX_RATIO interpolated frames per input frame, the
// last one flagged by last_of_run. Config: cfg_we_i writes input_rate,
// output_rate or active_channels; any of these clears the stream state.
// Write config only while the block is idle.
// The first frame after reset or a config write, and frames that fall
// between outputs, are accepted in the idle state. For a frame that
// produces outputs, each output frame waits on the shared bit-serial
// divider that forms the interpolation fraction, and the phase is folded
// at the end by repeated subtraction. Eight lane multipliers run in parallel.
// Reset restores 48000/48000 rates and 2 channels and clears the state.
// A single output register holds a finished frame; while the receiver
// stalls, the next frame waits in the lanes and in_stall_o stays high.
module linear_interp_audio_resampler_top #(
  parameter int MAX_RATIO = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  lires_pkg::in_frame_t                  in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output lires_pkg::out_frame_t                 out_data_o,
  input  logic                                  cfg_we_i,
  input  logic [lires_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [lires_pkg::RATE_BITS-1:0]       cfg_data_i
);

  localparam int RB   = lires_pkg::RATE_BITS;
  localparam int PB   = lires_pkg::PHASE_BITS;
  localparam int CB   = lires_pkg::CH_BITS;
  localparam int SKB  = lires_pkg::SKIP_BITS;
  localparam int LN   = lires_pkg::LANES;
  localparam int WIDE = RB + 4;
  localparam int CNTW = $clog2(MAX_RATIO + 1);
  localparam int KW   = 4;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_LANE  = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;
  localparam logic [2:0] ST_RED   = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [RB-1:0] cfg_in_q, cfg_out_q;
  logic [CB-1:0] cfg_ch_q;
  logic [RB-1:0] in_eff_q, out_eff_q, in_eff_d, out_eff_d;
  logic [CB-1:0] ch_q, ch_d;
  logic [RB-1:0] in_c, out_c;
  logic [WIDE-1:0] out_lim, in_lim;

  lires_pkg::smp_arr_t prev_q, prev_d, cur_q, cur_d, cur_in, lane_y;
  logic            primed_q, primed_d;
  logic [PB-1:0]   phase_q, phase_d;
  logic [SKB-1:0]  skip_q, skip_d;
  logic [RB:0]     r_q, r_d, r_next;
  logic [CNTW-1:0] cnt_q, cnt_d, cnt_inc;
  logic [KW-1:0]   k_q, k_d, k_dec;

  logic in_accept, cfg_clear;
  logic div_start, div_done, lane_start, lane_done, mrg_ready;
  logic [FRAC_BITS-1:0] frac;
  logic [LN-1:0] lane_done_w;
  lires_pkg::mrg_ctrl_t mrg_ctrl;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign cur_in     = lires_pkg::in_to_arr(in_data_i);
  assign cfg_clear  = cfg_we_i && (cfg_idx_i == lires_pkg::CFG_INPUT_RATE ||
                                   cfg_idx_i == lires_pkg::CFG_OUTPUT_RATE ||
                                   cfg_idx_i == lires_pkg::CFG_ACTIVE_CH);

  // effective rates: clamp to [1, 2^19], then limit the ratio
  always_comb begin
    in_c  = (cfg_in_q == '0) ? RB'(1) :
            (cfg_in_q > lires_pkg::MAX_RATE) ? lires_pkg::MAX_RATE : cfg_in_q;
    out_c = (cfg_out_q == '0) ? RB'(1) :
            (cfg_out_q > lires_pkg::MAX_RATE) ? lires_pkg::MAX_RATE : cfg_out_q;
    out_lim   = WIDE'(MAX_RATIO) * WIDE'(in_c);
    out_eff_d = (WIDE'(out_c) > out_lim) ? out_lim[RB-1:0] : out_c;
    in_lim    = WIDE'(MAX_RATIO) * WIDE'(out_eff_d);
    in_eff_d  = (WIDE'(in_c) > in_lim) ? in_lim[RB-1:0] : in_c;
    ch_d      = (cfg_ch_q == '0) ? CB'(1) :
                (cfg_ch_q > CB'(LN)) ? CB'(LN) : cfg_ch_q;
  end

  assign r_next  = r_q + {1'b0, in_eff_q};
  assign cnt_inc = cnt_q + 1'b1;
  assign k_dec   = k_q - 1'b1;

  always_comb begin
    state_d    = state_q;
    prev_d     = prev_q;
    cur_d      = cur_q;
    primed_d   = primed_q;
    phase_d    = phase_q;
    skip_d     = skip_q;
    r_d        = r_q;
    cnt_d      = cnt_q;
    k_d        = k_q;
    div_start  = 1'b0;
    lane_start = 1'b0;
    mrg_ctrl   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (!primed_q) begin
            primed_d = 1'b1;
            prev_d   = cur_in;
          end else if (skip_q != '0) begin
            skip_d = skip_q - 1'b1;
            prev_d = cur_in;
          end else begin
            cur_d   = cur_in;
            r_d     = (RB + 1)'(phase_q);
            cnt_d   = '0;
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (r_q < {1'b0, out_eff_q} && cnt_q < CNTW'(MAX_RATIO)) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          k_d     = '0;
          state_d = ST_RED;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          lane_start = 1'b1;
          state_d    = ST_LANE;
        end
      end
      ST_LANE: begin
        if (lane_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (mrg_ready) begin
          mrg_ctrl.load = 1'b1;
          mrg_ctrl.last = !(r_next < {1'b0, out_eff_q} && cnt_inc < CNTW'(MAX_RATIO));
          r_d     = r_next;
          cnt_d   = cnt_inc;
          state_d = ST_CHECK;
        end
      end
      ST_RED: begin
        // r / out_eff by repeated subtraction; the quotient is at most MAX_RATIO
        if (r_q >= {1'b0, out_eff_q}) begin
          r_d = r_q - {1'b0, out_eff_q};
          k_d = (k_q == '1) ? k_q : k_q + 1'b1;
        end else begin
          skip_d  = (k_q == '0) ? '0 :
                    (k_dec > KW'(7)) ? SKB'(7) : k_dec[SKB-1:0];
          phase_d = r_q[PB-1:0];
          prev_d  = cur_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (cfg_clear) begin
      prev_d   = '0;
      primed_d = 1'b0;
      phase_d  = '0;
      skip_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cfg_in_q  <= lires_pkg::RST_INPUT_RATE;
      cfg_out_q <= lires_pkg::RST_OUTPUT_RATE;
      cfg_ch_q  <= lires_pkg::RST_ACTIVE_CH;
      in_eff_q  <= lires_pkg::RST_INPUT_RATE;
      out_eff_q <= lires_pkg::RST_OUTPUT_RATE;
      ch_q      <= lires_pkg::RST_ACTIVE_CH;
      prev_q    <= '0;
      primed_q  <= 1'b0;
      phase_q   <= '0;
      skip_q    <= '0;
      cnt_q     <= '0;
      k_q       <= '0;
    end else begin
      state_q   <= state_d;
      in_eff_q  <= in_eff_d;
      out_eff_q <= out_eff_d;
      ch_q      <= ch_d;
      prev_q    <= prev_d;
      primed_q  <= primed_d;
      phase_q   <= phase_d;
      skip_q    <= skip_d;
      cnt_q     <= cnt_d;
      k_q       <= k_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          lires_pkg::CFG_INPUT_RATE:  cfg_in_q  <= cfg_data_i;
          lires_pkg::CFG_OUTPUT_RATE: cfg_out_q <= cfg_data_i;
          lires_pkg::CFG_ACTIVE_CH:   cfg_ch_q  <= cfg_data_i[CB-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    r_q   <= r_d;
  end

  lires_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (r_q[RB-1:0]),
    .divisor_i  (out_eff_q),
    .quot_o     (frac),
    .done_o     (div_done)
  );

  for (genvar i = 0; i < LN; i++) begin : g_lane
    lires_lane #(
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (lane_start),
      .cur_i   (cur_q[i]),
      .prev_i  (prev_q[i]),
      .frac_i  (frac),
      .done_o  (lane_done_w[i]),
      .y_o     (lane_y[i])
    );
  end

  assign lane_done = &lane_done_w;

  lires_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (mrg_ctrl),
    .lane_y_i    (lane_y),
    .ch_i        (ch_q),
    .ready_o     (mrg_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  `ASSERT_CLK(a_phase_below_rate, primed_q && state_q == ST_IDLE |-> RB'(phase_q) < out_eff_q)
  `ASSERT_CLK(a_cnt_cap, cnt_q <= CNTW'(MAX_RATIO))
  `ASSERT_CLK(a_skip_needs_primed, skip_q != '0 |-> primed_q)

endmodule
